// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by link_error_strike_table_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/lest_pkg.sv =====
// ----------------------------------------------------------------------------
// lest_pkg
// Types, codes and sizes shared by the link error strike table.
// ----------------------------------------------------------------------------
package lest_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W   = 48;
    localparam int CODE_W   = 8;
    localparam int STRIKE_W = 4;
    localparam int STATUS_W = 3;
    localparam int CLR_W    = 5;

    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    // controller error codes
    localparam logic [CODE_W-1:0] ERR_PAGE_TIMEOUT = 8'h04;
    localparam logic [CODE_W-1:0] ERR_NO_SDP       = 8'h54;
    localparam logic [CODE_W-1:0] ERR_ACL_RECREATE = 8'h57;

    localparam logic KIND_PAGE = 1'b0;
    localparam logic KIND_SDP  = 1'b1;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_IGNORED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_COUNTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NEW        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DROP_NOW   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DROP_LIMIT = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_CLEARED    = 3'd6;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PT_LIMIT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SDP_LIMIT = 2'd2;

    localparam logic [STRIKE_W-1:0] STRIKE_MAX = '1;
    localparam logic [STRIKE_W-1:0] STRIKE_ONE = 4'd1;
    localparam logic [CLR_W-1:0]    CLR_MAX    = '1;

    typedef struct packed {
        logic                enable;
        logic [STRIKE_W-1:0] pt_limit;
        logic [STRIKE_W-1:0] sdp_limit;
    } lest_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   addr;
        logic                kind;
        logic [STRIKE_W-1:0] count;
    } lest_rd_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic                valid;
        logic [ADDR_W-1:0]   addr;
        logic                kind;
        logic [STRIKE_W-1:0] count;
    } lest_wr_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                drop;
        logic [ADDR_W-1:0]   drop_addr;
        logic [STRIKE_W-1:0] strike;
        logic [CLR_W-1:0]    cleared;
    } lest_res_t;

endpackage

// ===== rtl/link_error_strike_table_core.sv =====
// ----------------------------------------------------------------------------
// link_error_strike_table_core
// Per-peer connection error strike table with APB register port.
// ----------------------------------------------------------------------------
// One transaction at a time. Error reports with codes 0x04 and 0x54 and clear
// requests walk the slot memory one slot per cycle through a single key
// comparator; a report that matches a slot ends its walk at that slot. Ignored
// requests and immediate drops (code 0x57) skip the walk. The walk length
// is set by the single read port of the slot memory. s_ready is low while a
// transaction is in progress; a finished result sits in the output register
// and the next transaction is accepted while it waits. No clearing pass after
// reset: slot valid flags are flops cleared by reset.
module link_error_strike_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lest_pkg::PADDR_W-1:0]  paddr,
    input  logic [lest_pkg::DATA_W-1:0]   pwdata,
    output logic [lest_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [lest_pkg::ADDR_W-1:0]   s_peer_addr,
    input  logic                          s_conn_is_classic,
    input  logic [lest_pkg::CODE_W-1:0]   s_error_code,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lest_pkg::STATUS_W-1:0] m_status,
    output logic                          m_drop_request,
    output logic [lest_pkg::ADDR_W-1:0]   m_drop_addr,
    output logic [lest_pkg::STRIKE_W-1:0] m_strike_count,
    output logic [lest_pkg::CLR_W-1:0]    m_cleared_entries
);
    import lest_pkg::*;
    `include "assert_macros.svh"

    lest_cfg_t cfg_reg, cfg_next;
    logic      m_valid_reg, m_valid_next;
    lest_res_t out_reg, out_next;

    logic                 reg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 out_free;
    logic                 seq_done;
    lest_res_t            seq_res;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    lest_rd_t             rd_data;
    lest_wr_t             tbl_wr;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (reg_wr) begin
            unique case (reg_idx)
                REG_ENABLE:    cfg_next.enable    = pwdata[0];
                REG_PT_LIMIT:  cfg_next.pt_limit  = pwdata[STRIKE_W-1:0];
                REG_SDP_LIMIT: cfg_next.sdp_limit = pwdata[STRIKE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE:    prdata = DATA_W'(cfg_reg.enable);
            REG_PT_LIMIT:  prdata = DATA_W'(cfg_reg.pt_limit);
            REG_SDP_LIMIT: prdata = DATA_W'(cfg_reg.sdp_limit);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable    <= 1'b1;
            cfg_reg.pt_limit  <= 4'd3;
            cfg_reg.sdp_limit <= 4'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- datapath ----------------
    lest_seq u_seq (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .in_valid           (s_valid),
        .in_ready           (s_ready),
        .in_req_type        (s_req_type),
        .in_peer_addr       (s_peer_addr),
        .in_conn_is_classic (s_conn_is_classic),
        .in_error_code      (s_error_code),
        .rd_en              (rd_en),
        .rd_idx             (rd_idx),
        .rd_data            (rd_data),
        .wr                 (tbl_wr),
        .done               (seq_done),
        .res                (seq_res),
        .res_take           (out_free)
    );

    lest_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr      (tbl_wr)
    );

    // ---------------- output register ----------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (out_free) begin
            m_valid_next = seq_done;
            if (seq_done) begin
                out_next = seq_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_drop_request    = out_reg.drop;
    assign m_drop_addr       = out_reg.drop_addr;
    assign m_strike_count    = out_reg.strike;
    assign m_cleared_entries = out_reg.cleared;

    // ---------------- assertions ----------------
    `ASSERT_PROP(a_busy_after_accept, aclk, aresetn,
        s_valid && s_ready |=> !s_ready, "accepted a transaction while busy")
    `ASSERT_PROP(a_result_held, aclk, aresetn, seq_done && !out_free |=> seq_done,
        "finished result lost before output register took it")
    `ASSERT_PROP(a_drop_matches_status, aclk, aresetn,
        m_valid |-> (m_drop_request ==
            (m_status == STAT_DROP_NOW || m_status == STAT_DROP_LIMIT)),
        "drop request disagrees with status")
    `ASSERT_NEVER(a_cleared_only_on_clear, aclk, aresetn,
        m_valid && m_status != STAT_CLEARED && m_cleared_entries != '0,
        "freed count on a non-clear result")

endmodule

// ===== rtl/lest_table.sv =====
// ----------------------------------------------------------------------------
// lest_table
// Slot store: address, kind and count memory with registered read, plus
// per-slot valid flops cleared by reset.
// ----------------------------------------------------------------------------
module lest_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [lest_pkg::IDX_W-1:0] rd_idx,
    output lest_pkg::lest_rd_t rd_data,
    input  lest_pkg::lest_wr_t wr
);
    import lest_pkg::*;

    logic [ADDR_W-1:0]   addr_mem  [TABLE_DEPTH];
    logic                kind_mem  [TABLE_DEPTH];
    logic [STRIKE_W-1:0] count_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    lest_rd_t               rd_data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (wr.en) begin
            valid_next[wr.idx] = wr.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            addr_mem[wr.idx]  <= wr.addr;
            kind_mem[wr.idx]  <= wr.kind;
            count_mem[wr.idx] <= wr.count;
        end
    end

    // read returns the contents before any write in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg.valid <= valid_reg[rd_idx];
            rd_data_reg.addr  <= addr_mem[rd_idx];
            rd_data_reg.kind  <= kind_mem[rd_idx];
            rd_data_reg.count <= count_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lest_seq.sv =====
// ----------------------------------------------------------------------------
// lest_seq
// Request sequencer: decodes a transaction, walks the slots one per cycle
// through a single key comparator and applies the update.
// ----------------------------------------------------------------------------
module lest_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lest_pkg::lest_cfg_t         cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_req_type,
    input  logic [lest_pkg::ADDR_W-1:0] in_peer_addr,
    input  logic                        in_conn_is_classic,
    input  logic [lest_pkg::CODE_W-1:0] in_error_code,
    output logic                        rd_en,
    output logic [lest_pkg::IDX_W-1:0]  rd_idx,
    input  lest_pkg::lest_rd_t          rd_data,
    output lest_pkg::lest_wr_t          wr,
    output logic                        done,
    output lest_pkg::lest_res_t         res,
    input  logic                        res_take
);
    import lest_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                req_reg, req_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                kind_reg, kind_next;
    logic [STRIKE_W-1:0] limit_reg, limit_next;
    logic [CLR_W-1:0]    freed_reg, freed_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    lest_res_t           res_reg, res_next;

    logic                hit;
    logic                last;
    logic [STRIKE_W-1:0] new_cnt;
    logic [CLR_W-1:0]    freed_inc;
    logic                at_limit;

    // shared comparator: one slot against the latched key per cycle
    assign hit = rd_data.valid && (rd_data.addr == addr_reg) &&
                 (req_reg == REQ_CLEAR || rd_data.kind == kind_reg);
    assign last      = (cmp_idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign new_cnt   = (rd_data.count == STRIKE_MAX) ? STRIKE_MAX : rd_data.count + STRIKE_ONE;
    assign at_limit  = (new_cnt >= limit_reg);
    assign freed_inc = (freed_reg == CLR_MAX) ? freed_reg : freed_reg + CLR_W'(1);

    assign in_ready = (state_reg == S_IDLE);
    assign done     = (state_reg == S_FIN);
    assign res      = res_reg;
    assign rd_idx   = cnt_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        cmp_vld_next    = cmp_vld_reg;
        cnt_next        = cnt_reg;
        cmp_idx_next    = cmp_idx_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        kind_next       = kind_reg;
        limit_next      = limit_reg;
        freed_next      = freed_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;
        rd_en           = 1'b0;
        wr              = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next        = in_req_type;
                    addr_next       = in_peer_addr;
                    kind_next       = (in_error_code == ERR_NO_SDP) ? KIND_SDP : KIND_PAGE;
                    limit_next      = (in_error_code == ERR_NO_SDP) ? cfg.sdp_limit
                                                                    : cfg.pt_limit;
                    cnt_next        = '0;
                    cmp_vld_next    = 1'b0;
                    freed_next      = '0;
                    free_found_next = 1'b0;
                    res_next        = '0;
                    if (!cfg.enable || !in_conn_is_classic) begin
                        res_next.status = STAT_IGNORED;
                        state_next      = S_FIN;
                    end else if (in_req_type == REQ_CLEAR) begin
                        state_next = S_SCAN;
                    end else if (in_error_code == ERR_ACL_RECREATE) begin
                        res_next.status    = STAT_DROP_NOW;
                        res_next.drop      = 1'b1;
                        res_next.drop_addr = in_peer_addr;
                        state_next         = S_FIN;
                    end else if (in_error_code == ERR_PAGE_TIMEOUT ||
                                 in_error_code == ERR_NO_SDP) begin
                        state_next = S_SCAN;
                    end else begin
                        res_next.status = STAT_IGNORED;
                        state_next      = S_FIN;
                    end
                end
            end

            S_SCAN: begin
                // read stage: issue one slot per cycle
                if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    rd_en        = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IDX_W-1:0];
                end else begin
                    cmp_vld_next = 1'b0;
                end

                // compare stage on the slot read last cycle
                if (cmp_vld_reg) begin
                    if (req_reg == REQ_CLEAR) begin
                        if (hit) begin
                            wr.en      = 1'b1;
                            wr.idx     = cmp_idx_reg;
                            wr.valid   = 1'b0;
                            wr.addr    = rd_data.addr;
                            wr.kind    = rd_data.kind;
                            wr.count   = rd_data.count;
                            freed_next = freed_inc;
                        end
                        if (last) begin
                            res_next.status  = STAT_CLEARED;
                            res_next.cleared = hit ? freed_inc : freed_reg;
                            state_next       = S_FIN;
                        end
                    end else if (hit) begin
                        wr.en    = 1'b1;
                        wr.idx   = cmp_idx_reg;
                        wr.valid = !at_limit;
                        wr.addr  = addr_reg;
                        wr.kind  = kind_reg;
                        wr.count = new_cnt;
                        res_next.strike = new_cnt;
                        if (at_limit) begin
                            res_next.status    = STAT_DROP_LIMIT;
                            res_next.drop      = 1'b1;
                            res_next.drop_addr = addr_reg;
                        end else begin
                            res_next.status = STAT_COUNTED;
                        end
                        cmp_vld_next = 1'b0;
                        state_next   = S_FIN;
                    end else begin
                        // remember the lowest free slot for a new entry
                        if (!rd_data.valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (last) begin
                            if (free_found_reg || !rd_data.valid) begin
                                wr.en    = 1'b1;
                                wr.idx   = free_found_reg ? free_idx_reg : cmp_idx_reg;
                                wr.valid = 1'b1;
                                wr.addr  = addr_reg;
                                wr.kind  = kind_reg;
                                wr.count = STRIKE_ONE;
                                res_next.status = STAT_NEW;
                                res_next.strike = STRIKE_ONE;
                            end else begin
                                res_next.status = STAT_FULL;
                            end
                            state_next = S_FIN;
                        end
                    end
                end
            end

            S_FIN: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        kind_reg       <= kind_next;
        limit_reg      <= limit_next;
        freed_reg      <= freed_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
    end

endmodule
